### rtl/crpcb_pkg.sv
// Shared types, constants and the pixel conversion for the clipped blit.
// No dependencies; every module of the block imports this package.
`default_nettype none
package crpcb_pkg;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DIRTY = 1'b1;

    localparam logic [1:0] REG_CROP_WIDTH    = 2'd0;
    localparam logic [1:0] REG_CROP_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd2;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd3;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    typedef struct packed {
        logic               opcode;
        logic signed [11:0] rect_x;
        logic signed [11:0] rect_y;
        logic [11:0]        rect_w;
        logic [11:0]        rect_h;
        logic [31:0]        pixel_bgrx;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [20:0] byte_address;
        logic [15:0] pixel_rgb555;
        logic [9:0]  dirty_top;
        logic [10:0] dirty_left;
        logic [9:0]  dirty_bottom;
        logic [10:0] dirty_right;
        logic [31:0] frame_sequence;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [10:0] crop_width;
        logic [9:0]  crop_height;
        logic [11:0] canvas_width;
        logic [11:0] canvas_height;
    } t_cfg;

    // queued work for the back end: a pixel write, a dirty summary, or both
    typedef struct packed {
        logic        wr;
        logic        dirty;
        logic [11:0] dx;
        logic [11:0] dy;
        logic [13:0] stride;
        logic [15:0] pix;
        logic [12:0] top;
        logic [12:0] left;
        logic [12:0] bottom;
        logic [12:0] right;
    } t_cmd;

    function automatic logic [15:0] to_rgb555_swapped(input logic [31:0] bgrx);
        logic [15:0] p;
        p = {1'b0, bgrx[23:19], bgrx[15:11], bgrx[7:3]};
        return {p[7:0], p[15:8]};
    endfunction

endpackage
`default_nettype wire

### rtl/crpcb_front.sv
// Front end: takes headers and pixels, clips, tracks position, queues work.
// Depends on crpcb_pkg.
`default_nettype none
module crpcb_front #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 768
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  crpcb_pkg::t_cfg     i_cfg,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  crpcb_pkg::t_in      i_in_data,
    input  wire                 i_full,
    output logic                o_push,
    output crpcb_pkg::t_cmd     o_cmd
);
    import crpcb_pkg::*;

    localparam logic [12:0] MAX_W13 = 13'(MAX_WIDTH);
    localparam logic [12:0] MAX_H13 = 13'(MAX_HEIGHT);

    logic [11:0]        r_src_w, r_src_h, r_col, r_row;
    logic signed [11:0] r_x, r_y;
    logic [12:0]        r_left, r_top, r_right, r_bottom;
    logic [13:0]        r_stride;
    logic               r_nz;

    logic               accept, is_hdr, active, col_last, done, in_x, in_y, wr, dirty;
    logic               use_canvas, h_nz;
    logic [11:0]        cw_sel, ch_sel;
    logic [12:0]        cw13, ch13, col_inc, row_inc;
    logic signed [13:0] hx, hy, hr, hb, hrc, hbc, hl, ht, cws, chs, px, py;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_hdr     = (i_in_data.opcode == OP_HEADER);

    // header clipping
    always_comb begin
        use_canvas = (i_cfg.crop_width == 11'd0) || (i_cfg.crop_height == 10'd0);
        cw_sel = use_canvas ? i_cfg.canvas_width  : {1'b0, i_cfg.crop_width};
        ch_sel = use_canvas ? i_cfg.canvas_height : {2'b00, i_cfg.crop_height};
        cw13 = ({1'b0, cw_sel} > MAX_W13) ? MAX_W13 : {1'b0, cw_sel};
        ch13 = ({1'b0, ch_sel} > MAX_H13) ? MAX_H13 : {1'b0, ch_sel};
        cws  = $signed({1'b0, cw13});
        chs  = $signed({1'b0, ch13});
        hx   = {{2{i_in_data.rect_x[11]}}, i_in_data.rect_x};
        hy   = {{2{i_in_data.rect_y[11]}}, i_in_data.rect_y};
        hr   = hx + $signed({2'b00, i_in_data.rect_w});
        hb   = hy + $signed({2'b00, i_in_data.rect_h});
        hrc  = (hr > cws) ? cws : hr;
        hbc  = (hb > chs) ? chs : hb;
        hl   = hx[13] ? 14'sd0 : hx;
        ht   = hy[13] ? 14'sd0 : hy;
        h_nz = (hrc > hl) && (hbc > ht);
    end

    // pixel tracking; destination = rect origin + source position
    always_comb begin
        active   = (r_src_w != 12'd0) && (r_src_h != 12'd0) && (r_row < r_src_h);
        col_inc  = {1'b0, r_col} + 13'd1;
        row_inc  = {1'b0, r_row} + 13'd1;
        col_last = (col_inc >= {1'b0, r_src_w});
        done     = col_last && (row_inc >= {1'b0, r_src_h});
        px       = {{2{r_x[11]}}, r_x} + $signed({2'b00, r_col});
        py       = {{2{r_y[11]}}, r_y} + $signed({2'b00, r_row});
        in_x     = (px >= $signed({1'b0, r_left})) && (px < $signed({1'b0, r_right}));
        in_y     = (py >= $signed({1'b0, r_top}))  && (py < $signed({1'b0, r_bottom}));
        wr       = in_x && in_y;
        dirty    = done && r_nz;
    end

    assign o_push = accept && !is_hdr && active && (wr || dirty);

    always_comb begin
        o_cmd.wr     = wr;
        o_cmd.dirty  = dirty;
        o_cmd.dx     = px[11:0];
        o_cmd.dy     = py[11:0];
        o_cmd.stride = r_stride;
        o_cmd.pix    = to_rgb555_swapped(i_in_data.pixel_bgrx);
        o_cmd.top    = r_top;
        o_cmd.left   = r_left;
        o_cmd.bottom = r_bottom;
        o_cmd.right  = r_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= '0;
            r_src_h <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_nz    <= 1'b0;
        end else if (accept && is_hdr) begin
            r_src_w <= i_in_data.rect_w;
            r_src_h <= i_in_data.rect_h;
            r_col   <= '0;
            r_row   <= '0;
            r_nz    <= h_nz;
        end else if (accept && active) begin
            r_col <= col_last ? 12'd0 : col_inc[11:0];
            r_row <= col_last ? row_inc[11:0] : r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_hdr) begin
            r_x      <= i_in_data.rect_x;
            r_y      <= i_in_data.rect_y;
            r_stride <= {cw13, 1'b0};
            r_left   <= h_nz ? hl[12:0]  : 13'd0;
            r_top    <= h_nz ? ht[12:0]  : 13'd0;
            r_right  <= h_nz ? hrc[12:0] : 13'd0;
            r_bottom <= h_nz ? hbc[12:0] : 13'd0;
        end
    end

endmodule
`default_nettype wire

### rtl/crpcb_queue.sv
// Small register queue between the front and back ends.
// Depends on crpcb_pkg.
`default_nettype none
module crpcb_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  crpcb_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output crpcb_pkg::t_cmd o_cmd
);
    import crpcb_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)    r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !pop)      r_count <= r_count + 1'b1;
            else if (!i_push && pop) r_count <= r_count - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < (QPTR_W+1)'(QDEPTH)))
        else $error("queue push while full");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule
`default_nettype wire

### rtl/crpcb_back.sv
// Back end: address multiply, splits write and dirty results, output register.
// Depends on crpcb_pkg.
`default_nettype none
module crpcb_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_valid,
    output logic            o_q_pop,
    input  crpcb_pkg::t_cmd i_cmd,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output crpcb_pkg::t_out o_out_data
);
    import crpcb_pkg::*;

    logic        r_m_valid;
    t_cmd        r_m_cmd;
    logic [20:0] r_m_prod;
    logic [31:0] r_seq;
    logic        r_o_valid;
    t_out        r_o_data;

    logic        o_adv, emit, m_final;
    logic [25:0] prod;
    t_out        res;

    assign o_adv   = !r_o_valid || i_out_ready;
    assign emit    = o_adv && r_m_valid;
    assign m_final = !(r_m_cmd.wr && r_m_cmd.dirty);
    assign o_q_pop = i_q_valid && (!r_m_valid || (emit && m_final));
    assign prod    = i_cmd.dy * i_cmd.stride;

    always_comb begin
        res = '0;
        if (r_m_cmd.wr) begin
            res.kind         = KIND_WRITE;
            res.byte_address = r_m_prod + {8'd0, r_m_cmd.dx, 1'b0};
            res.pixel_rgb555 = r_m_cmd.pix;
            res.last         = !r_m_cmd.dirty;
        end else begin
            res.kind           = KIND_DIRTY;
            res.dirty_top      = r_m_cmd.top[9:0];
            res.dirty_left     = r_m_cmd.left[10:0];
            res.dirty_bottom   = r_m_cmd.bottom[9:0];
            res.dirty_right    = r_m_cmd.right[10:0];
            res.frame_sequence = r_seq + 32'd1;
            res.last           = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_seq     <= '0;
        end else begin
            if (emit && m_final) r_m_valid <= 1'b0;
            if (o_q_pop)         r_m_valid <= 1'b1;
            if (o_adv)           r_o_valid <= r_m_valid;
            if (emit && !r_m_cmd.wr) r_seq <= r_seq + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_cmd  <= i_cmd;
            r_m_prod <= prod[20:0];
        end else if (emit && !m_final) begin
            r_m_cmd.wr <= 1'b0;
        end
        if (emit) r_o_data <= res;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    a_dirty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.kind == KIND_DIRTY) |-> r_o_data.last)
        else $error("dirty result not marked last");

    a_seq_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.kind == KIND_DIRTY) |-> (r_o_data.frame_sequence == r_seq))
        else $error("frame sequence out of step");

    a_pending_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.kind == KIND_WRITE && !r_o_data.last)
            |-> (r_m_valid && !r_m_cmd.wr && r_m_cmd.dirty))
        else $error("write without last has no dirty result pending");

endmodule
`default_nettype wire

### rtl/clipped_rect_pixel_convert_blit_top.sv
// Clipped rectangle blit, BGRX8888 to byte-swapped RGB555: top level.
// Holds the configuration registers; depends on crpcb_pkg, crpcb_front,
// crpcb_queue and crpcb_back.
//
// Accepts one header or source pixel per cycle while the queue is not full
// and delivers one result per cycle while the receiver is ready. A pixel
// result passes the queue entry, address multiply stage and output register.
// The final pixel of a rectangle with a non-empty clip gives a dirty summary,
// after a write if that pixel is in the clip; a four-entry queue absorbs that
// and short output stalls. Configuration changes apply at the next header.
`default_nettype none
module clipped_rect_pixel_convert_blit_top #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 768
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             psel,
    input  wire             penable,
    input  wire             pwrite,
    input  wire [3:0]       paddr,
    input  wire [31:0]      pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  crpcb_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output crpcb_pkg::t_out o_out_data
);
    import crpcb_pkg::*;

    t_cfg r_cfg;
    logic q_full, q_push, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crop_width    <= 11'd0;
            r_cfg.crop_height   <= 10'd0;
            r_cfg.canvas_width  <= 12'd1024;
            r_cfg.canvas_height <= 12'd768;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_CROP_WIDTH:    r_cfg.crop_width    <= pwdata[10:0];
                REG_CROP_HEIGHT:   r_cfg.crop_height   <= pwdata[9:0];
                REG_CANVAS_WIDTH:  r_cfg.canvas_width  <= pwdata[11:0];
                REG_CANVAS_HEIGHT: r_cfg.canvas_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CROP_WIDTH:    prdata = {21'd0, r_cfg.crop_width};
            REG_CROP_HEIGHT:   prdata = {22'd0, r_cfg.crop_height};
            REG_CANVAS_WIDTH:  prdata = {20'd0, r_cfg.canvas_width};
            REG_CANVAS_HEIGHT: prdata = {20'd0, r_cfg.canvas_height};
            default:           prdata = '0;
        endcase
    end

    crpcb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    crpcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    crpcb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for clipped_rect_pixel_convert_blit_top: it sends rectangle headers
// and source pixels over valid/ready, predicts writes and dirty summaries, and checks each one.
// Depends on crpcb_pkg and the RTL top level.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crpcb_pkg::*;

    localparam int VIEW_MAX_W    = 1024;
    localparam int VIEW_MAX_H    = 768;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;

    class blit_scoreboard;
        bit [10:0] crop_w;
        bit [9:0]  crop_h;
        bit [11:0] canvas_w;
        bit [11:0] canvas_h;
        bit [10:0] clip_l;
        bit [10:0] clip_wd;
        bit [9:0]  clip_t;
        bit [9:0]  clip_ht;
        bit [11:0] skip_x, skip_y, src_w, src_h, col, row, stride;
        bit [31:0] frame_seq;
        t_out      expected_q[$];
        int        mismatches;

        function new();
            canvas_w = 12'd1024;
            canvas_h = 12'd768;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_CROP_WIDTH:    crop_w = v[10:0];
                REG_CROP_HEIGHT:   crop_h = v[9:0];
                REG_CANVAS_WIDTH:  canvas_w = v[11:0];
                REG_CANVAS_HEIGHT: canvas_h = v[11:0];
                default: ;
            endcase
        endfunction

        function void viewport(output int vw, output int vh);
            vw = crop_w;
            vh = crop_h;
            if (vw == 0 || vh == 0) begin
                vw = canvas_w;
                vh = canvas_h;
            end
            if (vw > VIEW_MAX_W) vw = VIEW_MAX_W;
            if (vh > VIEW_MAX_H) vh = VIEW_MAX_H;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_in d);
            int   x, y, w, h, vw, vh, l, t, r, b, c, rw, dx, dy;
            t_out wr, dr;
            bit   has_wr, has_dirty;
            if (d.opcode == OP_HEADER) begin
                x = $signed(d.rect_x);
                y = $signed(d.rect_y);
                w = d.rect_w;
                h = d.rect_h;
                viewport(vw, vh);
                src_w = 12'(w);
                src_h = 12'(h);
                col = '0;
                row = '0;
                skip_x = 12'((x < 0) ? -x : 0);
                skip_y = 12'((y < 0) ? -y : 0);
                stride = 12'(vw * 2);
                l = (x < 0) ? 0 : x;
                t = (y < 0) ? 0 : y;
                r = (x + w > vw) ? vw : x + w;
                b = (y + h > vh) ? vh : y + h;
                if (r > l && b > t) begin
                    clip_l = 11'(l);
                    clip_t = 10'(t);
                    clip_wd = 11'(r - l);
                    clip_ht = 10'(b - t);
                end else begin
                    clip_l = '0;
                    clip_t = '0;
                    clip_wd = '0;
                    clip_ht = '0;
                end
            end else begin
                if (src_w == 0 || src_h == 0 || row >= src_h) return;
                c = col;
                rw = row;
                has_wr = (c >= skip_x) && (c - skip_x < clip_wd) &&
                         (rw >= skip_y) && (rw - skip_y < clip_ht);
                if (has_wr) begin
                    dy = clip_t + (rw - skip_y);
                    dx = clip_l + (c - skip_x);
                    wr = '0;
                    wr.kind = KIND_WRITE;
                    wr.byte_address = 21'(dy * stride + dx * 2);
                    // RGB555 high byte sits in the low byte of the field
                    wr.pixel_rgb555 = {d.pixel_bgrx[13:11], d.pixel_bgrx[7:3], 1'b0,
                                       d.pixel_bgrx[23:19], d.pixel_bgrx[15:14]};
                end
                c++;
                if (c >= src_w) begin
                    c = 0;
                    rw++;
                end
                col = 12'(c);
                row = 12'(rw);
                has_dirty = (rw >= src_h) && clip_wd != 0 && clip_ht != 0;
                if (has_dirty) begin
                    frame_seq++;
                    dr = '0;
                    dr.kind = KIND_DIRTY;
                    dr.dirty_top = clip_t;
                    dr.dirty_left = clip_l;
                    dr.dirty_bottom = 10'(clip_t + clip_ht);
                    dr.dirty_right = 11'(clip_l + clip_wd);
                    dr.frame_sequence = frame_seq;
                    dr.last = 1'b1;
                end
                if (has_wr) begin
                    wr.last = !has_dirty;
                    expected_q.push_back(wr);
                end
                if (has_dirty) expected_q.push_back(dr);
            end
        endfunction

        function void report(string what, t_out e, t_out g);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s at %0t", what, $time);
                $display("  exp kind %0d adr %h pix %h tlbr %0d %0d %0d %0d seq %0d last %0d",
                         e.kind, e.byte_address, e.pixel_rgb555, e.dirty_top, e.dirty_left,
                         e.dirty_bottom, e.dirty_right, e.frame_sequence, e.last);
                $display("  got kind %0d adr %h pix %h tlbr %0d %0d %0d %0d seq %0d last %0d",
                         g.kind, g.byte_address, g.pixel_rgb555, g.dirty_top, g.dirty_left,
                         g.dirty_bottom, g.dirty_right, g.frame_sequence, g.last);
            end
        endfunction

        function void check_result(t_out g);
            t_out e;
            if (expected_q.size() == 0) begin
                report("unexpected result", '0, g);
                return;
            end
            e = expected_q.pop_front();
            if (g.kind !== e.kind || g.byte_address !== e.byte_address ||
                g.pixel_rgb555 !== e.pixel_rgb555 || g.dirty_top !== e.dirty_top ||
                g.dirty_left !== e.dirty_left || g.dirty_bottom !== e.dirty_bottom ||
                g.dirty_right !== e.dirty_right || g.frame_sequence !== e.frame_sequence ||
                g.last !== e.last)
                report("result mismatch", e, g);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;

    blit_scoreboard sb = new();
    bit          sender_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int unsigned stall_cycles = 0;

    clipped_rect_pixel_convert_blit_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) sb.note_input(in_data);
            if (out_valid && out_ready) sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("clipped_rect_pixel_convert_blit_top verification failed");
        $finish;
    end

    // receiver: random back-pressure, or a long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= rx_idle_en ? ($urandom_range(99) >= 24) : 1'b1;
            end
        end
    end

    function automatic t_in make_header(input int x, input int y, input int w, input int h);
        t_in d;
        d.opcode = OP_HEADER;
        d.rect_x = x[11:0];
        d.rect_y = y[11:0];
        d.rect_w = w[11:0];
        d.rect_h = h[11:0];
        d.pixel_bgrx = $urandom;
        return d;
    endfunction

    function automatic t_in make_pixel(input logic [31:0] bgrx);
        t_in d;
        d.opcode = OP_PIXEL;
        d.rect_x = 12'($urandom);
        d.rect_y = 12'($urandom);
        d.rect_w = 12'($urandom);
        d.rect_h = 12'($urandom);
        d.pixel_bgrx = bgrx;
        return d;
    endfunction

    task automatic drive_item(input t_in d);
        while (sender_idle_en && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [10:0] cw, input logic [9:0] ch,
                                input logic [11:0] vw, input logic [11:0] vh);
        logic [1:0]  reg_idx [4];
        logic [31:0] vals [4];
        int          k;
        reg_idx = '{REG_CROP_WIDTH, REG_CROP_HEIGHT, REG_CANVAS_WIDTH, REG_CANVAS_HEIGHT};
        vals = '{32'(cw), 32'(ch), 32'(vw), 32'(vh)};
        for (k = 0; k < 4; k++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {reg_idx[k], 2'b00};
            pwdata <= vals[k];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            sb.set_reg(reg_idx[k], vals[k]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_directed();
        drive_item(make_pixel(32'hFFFF_FFFF));                 // stray before any header
        drive_item(make_header(-2048, -2048, 4095, 4095));
        drive_item(make_pixel(32'h0000_0000));
        drive_item(make_header(2047, 2047, 1, 1));             // wholly outside
        drive_item(make_pixel(32'hA5A5_A5A5));
        drive_item(make_pixel(32'h5A5A_5A5A));                 // stray after completion
        drive_item(make_header(0, 0, 0, 5));                   // empty rectangle
        drive_item(make_pixel(32'h1234_5678));
        drive_item(make_header(-1, -1, 2, 2));
        drive_item(make_pixel(32'h00F8_0000));
        drive_item(make_pixel(32'h0000_F800));
        drive_item(make_pixel(32'h0000_00F8));
        drive_item(make_pixel(32'hFF07_0707));
        drive_item(make_header(1022, 766, 3, 3));
        drive_item(make_pixel(32'hFFFF_FFFF));
        drive_item(make_pixel(32'h0000_0000));
        drive_item(make_pixel(32'h00FF_0000));
        drive_item(make_pixel(32'h0000_FF00));
        drive_item(make_pixel(32'h0000_00FF));
        drive_item(make_pixel(32'h0008_0808));
        drive_item(make_pixel(32'hFFF7_F7F7));
        drive_item(make_pixel(32'h8040_2010));
        drive_item(make_pixel(32'h7FBF_DFEF));
        drive_item(make_header(5, 5, 1, 1));
        drive_item(make_pixel(32'hDEAD_BEEF));
    endtask

    task automatic run_phase(input int target, input bit quiet, input bit hold);
        int sent, vw, vh, w, h, x, y, npix, sel, k;
        bit paused;
        sender_idle_en = !quiet;
        rx_idle_en = !quiet;
        if (hold) hold_request = 1'b1;
        sb.viewport(vw, vh);
        sent = 0;
        paused = 1'b0;
        while (sent < target) begin
            sel = $urandom_range(99);
            w = $urandom_range(1, (sel < 8) ? 40 : 12);
            h = $urandom_range(1, (sel < 8) ? 4 : 6);
            x = $urandom_range(0, vw + 2 * w) - w;
            y = $urandom_range(0, vh + 2 * h) - h;
            if (sel < 82) begin
                // full rectangle, or a truncated one that the next header abandons
                npix = (sel < 72) ? w * h : $urandom_range(0, w * h - 1);
                drive_item(make_header(x, y, w, h));
                for (k = 0; k < npix; k++) drive_item(make_pixel($urandom));
                sent += 1 + npix;
            end else if (sel < 92) begin
                npix = $urandom_range(0, 4);
                drive_item(make_header($urandom, $urandom, $urandom, $urandom));
                for (k = 0; k < npix; k++) drive_item(make_pixel($urandom));
                sent += 1 + npix;
            end else begin
                drive_item(make_pixel($urandom));
                sent += 1;
            end
            if (!paused && sent >= target / 2) begin
                paused = 1'b1;
                wait_drained(0);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_drained(SETTLE_CYCLES);
        write_config(11'd1024, 10'd768, 12'd1024, 12'd768);
        run_phase(240, 1'b0, 1'b1);
        wait_drained(SETTLE_CYCLES);
        write_config(11'd2047, 10'd1023, 12'd4095, 12'd4095);
        run_phase(240, 1'b1, 1'b0);
        wait_drained(SETTLE_CYCLES);
        write_config(11'd1, 10'd1, 12'd1024, 12'd768);
        run_phase(150, 1'b0, 1'b0);
        wait_drained(SETTLE_CYCLES);
        write_config(11'd0, 10'd300, 12'd4095, 12'd4095);
        run_phase(240, 1'b0, 1'b1);
        wait_drained(SETTLE_CYCLES);
        write_config(11'd640, 10'd0, 12'd37, 12'd29);
        run_phase(240, 1'b0, 1'b0);
        wait_drained(SETTLE_CYCLES);
        write_config(11'd0, 10'd0, 12'd0, 12'd500);
        run_phase(60, 1'b0, 1'b0);
        wait_drained(SETTLE_CYCLES);
        write_config(11'd0, 10'd0, 12'd16, 12'd1);
        run_phase(150, 1'b0, 1'b0);
        repeat (3) begin
            wait_drained(SETTLE_CYCLES);
            write_config(11'($urandom_range(1, 1100)), 10'($urandom_range(0, 800)),
                         12'($urandom), 12'($urandom));
            run_phase(200, 1'b0, 1'b0);
        end
        wait_drained(SETTLE_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("clipped_rect_pixel_convert_blit_top verification clean");
        end else begin
            $display("clipped_rect_pixel_convert_blit_top verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
